[rtl/core/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared types, codes and helper functions for the linear envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // Width of the ramp length registers and of the level registers.
    localparam int RAMP_W  = 24;
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    // Unity level in Q1.15 and the level at or below which the output is zero.
    localparam logic [LEVEL_W-1:0] LEVEL_ONE     = 16'd32768;
    localparam logic [LEVEL_W-1:0] EPSILON_LEVEL = 16'd3;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] IDX_ATTACK  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_DECAY   = 3'd1;
    localparam logic [IDX_W-1:0] IDX_RELEASE = 3'd2;
    localparam logic [IDX_W-1:0] IDX_START   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_SUSTAIN = 3'd4;

    // Function codes of an input request.
    localparam logic [1:0] FUNC_EVAL     = 2'd0;
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

    // Stage codes of a result.
    localparam logic [1:0] STAGE_ATTACK  = 2'd0;
    localparam logic [1:0] STAGE_DECAY   = 2'd1;
    localparam logic [1:0] STAGE_SUSTAIN = 2'd2;
    localparam logic [1:0] STAGE_RELEASE = 2'd3;

    // Current envelope settings.
    typedef struct packed {
        logic [RAMP_W-1:0]  attack;
        logic [RAMP_W-1:0]  decay;
        logic [RAMP_W-1:0]  release_len;
        logic [LEVEL_W-1:0] start;
        logic [LEVEL_W-1:0] sustain;
    } cfg_t;

    // Note trigger state.
    typedef struct packed {
        logic              held;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
    } note_t;

    // Result handed from the calculation unit to the output stage.
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] amp;
        logic [1:0]         stage;
    } calc_res_t;

    // Saturate a raw level to unity and squash tiny levels to zero.
    function automatic logic [LEVEL_W-1:0] finish_amp(input logic [LEVEL_W:0] raw);
        logic [LEVEL_W-1:0] r;
        if (raw > {1'b0, LEVEL_ONE})
        begin
            r = LEVEL_ONE;
        end
        else if (raw <= {1'b0, EPSILON_LEVEL})
        begin
            r = '0;
        end
        else
        begin
            r = raw[LEVEL_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/adsr_cfg.sv]
// ----------------------------------------------------------------------------
// ADSR configuration registers
// Holds the ramp lengths and levels, forcing ramps to at least one sample
// and levels to at most unity.
// ----------------------------------------------------------------------------
module adsr_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [adsr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_W-1:0]    cfg_wdata,
    output adsr_pkg::cfg_t                cfg
);

    adsr_pkg::cfg_t cfg_reg;
    adsr_pkg::cfg_t cfg_next;

    logic [adsr_pkg::RAMP_W-1:0]  ramp_val;
    logic [adsr_pkg::LEVEL_W-1:0] level_val;

    // Legalize the written value for both register kinds.
    always_comb
    begin
        ramp_val  = (cfg_wdata[adsr_pkg::RAMP_W-1:0] == '0) ? 24'd1
                                                            : cfg_wdata[adsr_pkg::RAMP_W-1:0];
        level_val = (cfg_wdata[adsr_pkg::LEVEL_W-1:0] > adsr_pkg::LEVEL_ONE)
                    ? adsr_pkg::LEVEL_ONE : cfg_wdata[adsr_pkg::LEVEL_W-1:0];
    end

    // Register select; unknown indexes leave everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                adsr_pkg::IDX_ATTACK:  cfg_next.attack      = ramp_val;
                adsr_pkg::IDX_DECAY:   cfg_next.decay       = ramp_val;
                adsr_pkg::IDX_RELEASE: cfg_next.release_len = ramp_val;
                adsr_pkg::IDX_START:   cfg_next.start       = level_val;
                adsr_pkg::IDX_SUSTAIN: cfg_next.sustain     = level_val;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack      <= 24'd882;
            cfg_reg.decay       <= 24'd441;
            cfg_reg.release_len <= 24'd882;
            cfg_reg.start       <= 16'd32768;
            cfg_reg.sustain     <= 16'd26214;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/adsr_calc.sv]
// ----------------------------------------------------------------------------
// ADSR level calculation unit
// Sequencer around one shared multiplier and one shared compare/subtract
// unit that performs a restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adsr_calc
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           ack,
    input  logic [adsr_pkg::TIME_W-1:0]    sample_time,
    input  adsr_pkg::note_t                note,
    input  adsr_pkg::cfg_t                 cfg,
    output adsr_pkg::calc_res_t            res
);

    localparam int OP_W   = 33;
    localparam int PROD_W = 49;
    localparam int NUM_W  = 50;
    localparam int QUO_W  = 17;
    localparam int CMP_W  = 34;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_CHK,
        ST_DIV_RUN,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [adsr_pkg::LEVEL_W-1:0]  lvl_a_reg;
    logic [OP_W-1:0]               op_a_reg;
    logic [adsr_pkg::LEVEL_W-1:0]  lvl_b_reg;
    logic [OP_W-1:0]               op_b_reg;
    logic                          two_terms_reg;
    logic [adsr_pkg::RAMP_W-1:0]   divisor_reg;
    logic [NUM_W-1:0]              num_reg;
    logic [adsr_pkg::RAMP_W-1:0]   rem_reg;
    logic [QUO_W-1:0]              quo_reg;
    logic [4:0]                    cnt_reg;
    logic [adsr_pkg::LEVEL_W-1:0]  amp_reg;
    logic [1:0]                    stage_reg;

    // Phase classification of the current request.
    logic [adsr_pkg::TIME_W-1:0]   life;
    logic [adsr_pkg::RAMP_W:0]     a_plus_d;
    logic                          before_on;
    logic                          in_attack;
    logic                          in_decay;
    logic [adsr_pkg::RAMP_W-1:0]   decay_pos;
    logic                          before_off;
    logic [adsr_pkg::TIME_W-1:0]   back;
    logic [adsr_pkg::TIME_W-1:0]   since_off;
    logic                          release_over;

    always_comb
    begin
        life         = sample_time - note.on_time;
        a_plus_d     = {1'b0, cfg.attack} + {1'b0, cfg.decay};
        before_on    = sample_time < note.on_time;
        in_attack    = life <= {8'b0, cfg.attack};
        in_decay     = life <= {7'b0, a_plus_d};
        decay_pos    = life[adsr_pkg::RAMP_W-1:0] - cfg.attack;
        before_off   = sample_time < note.off_time;
        back         = note.off_time - sample_time;
        since_off    = sample_time - note.off_time;
        release_over = since_off >= {8'b0, cfg.release_len};
    end

    // Shared multiplier: level times ramp operand.
    logic [adsr_pkg::LEVEL_W-1:0] mul_lvl;
    logic [OP_W-1:0]              mul_op;
    logic [PROD_W-1:0]            prod;

    always_comb
    begin
        mul_lvl = (state_reg == ST_MUL_B) ? lvl_b_reg : lvl_a_reg;
        mul_op  = (state_reg == ST_MUL_B) ? op_b_reg  : op_a_reg;
        prod    = PROD_W'({16'b0, mul_op} * {33'b0, mul_lvl});
    end

    // Shared compare/subtract unit for the overflow check and each division step.
    logic [OP_W-1:0]  cmp_a;
    logic [CMP_W-1:0] cmp_diff;
    logic             cmp_ge;
    logic [QUO_W-1:0] quo_last;

    always_comb
    begin
        if (state_reg == ST_DIV_CHK)
        begin
            cmp_a = num_reg[NUM_W-1:QUO_W];
        end
        else
        begin
            cmp_a = {8'b0, rem_reg, num_reg[QUO_W-1]};
        end
        cmp_diff = {1'b0, cmp_a} - {10'b0, divisor_reg};
        cmp_ge   = !cmp_diff[CMP_W-1];
        quo_last = {quo_reg[QUO_W-2:0], cmp_ge};
    end

    // Sequencer, datapath registers and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_CLASSIFY;
                    end
                end

                ST_CLASSIFY:
                begin
                    two_terms_reg <= 1'b0;
                    op_b_reg      <= '0;
                    lvl_b_reg     <= cfg.sustain;
                    if (note.held)
                    begin
                        if (before_on)
                        begin
                            stage_reg <= adsr_pkg::STAGE_ATTACK;
                            amp_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else if (in_attack)
                        begin
                            stage_reg   <= adsr_pkg::STAGE_ATTACK;
                            lvl_a_reg   <= cfg.start;
                            op_a_reg    <= {9'b0, life[adsr_pkg::RAMP_W-1:0]};
                            divisor_reg <= cfg.attack;
                            state_reg   <= ST_MUL_A;
                        end
                        else if (in_decay)
                        begin
                            stage_reg     <= adsr_pkg::STAGE_DECAY;
                            lvl_a_reg     <= cfg.start;
                            op_a_reg      <= {9'b0, cfg.decay - decay_pos};
                            op_b_reg      <= {9'b0, decay_pos};
                            two_terms_reg <= 1'b1;
                            divisor_reg   <= cfg.decay;
                            state_reg     <= ST_MUL_A;
                        end
                        else
                        begin
                            stage_reg <= adsr_pkg::STAGE_SUSTAIN;
                            amp_reg   <= adsr_pkg::finish_amp({1'b0, cfg.sustain});
                            state_reg <= ST_DONE;
                        end
                    end
                    else
                    begin
                        stage_reg   <= adsr_pkg::STAGE_RELEASE;
                        lvl_a_reg   <= cfg.sustain;
                        divisor_reg <= cfg.release_len;
                        if (before_off)
                        begin
                            op_a_reg  <= {9'b0, cfg.release_len} + {1'b0, back};
                            state_reg <= ST_MUL_A;
                        end
                        else if (release_over)
                        begin
                            amp_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            op_a_reg  <= {9'b0, cfg.release_len
                                               - since_off[adsr_pkg::RAMP_W-1:0]};
                            state_reg <= ST_MUL_A;
                        end
                    end
                end

                ST_MUL_A:
                begin
                    num_reg   <= {1'b0, prod};
                    state_reg <= two_terms_reg ? ST_MUL_B : ST_DIV_CHK;
                end

                ST_MUL_B:
                begin
                    num_reg   <= num_reg + {1'b0, prod};
                    state_reg <= ST_DIV_CHK;
                end

                ST_DIV_CHK:
                begin
                    // A quotient too wide for the result saturates to unity.
                    if (cmp_ge)
                    begin
                        amp_reg   <= adsr_pkg::LEVEL_ONE;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        rem_reg   <= num_reg[NUM_W-10:QUO_W];
                        quo_reg   <= '0;
                        cnt_reg   <= 5'd16;
                        state_reg <= ST_DIV_RUN;
                    end
                end

                ST_DIV_RUN:
                begin
                    rem_reg <= cmp_ge ? cmp_diff[adsr_pkg::RAMP_W-1:0]
                                      : cmp_a[adsr_pkg::RAMP_W-1:0];
                    quo_reg <= quo_last;
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        amp_reg   <= adsr_pkg::finish_amp(quo_last);
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.valid = (state_reg == ST_DONE);
        res.amp   = amp_reg;
        res.stage = stage_reg;
    end

endmodule

[rtl/core/adsr_envelope_generator.sv]
// ----------------------------------------------------------------------------
// Linear ADSR envelope generator
// Top level: request channel, note trigger state, output register.
// ----------------------------------------------------------------------------
// Each input request carries a function code in s_tuser (evaluate, note on,
// note off) and an absolute sample time in s_tdata. A note on or note off
// updates the trigger state first; every request then yields exactly one
// result with the Q1.15 amplitude in m_tdata and the stage in m_tuser.
// Settings are to be written through cfg_wr_en/cfg_index/cfg_wdata only while
// idle; the block does not enforce this. One request is worked on at a time
// and s_tready is low meanwhile. A ramp value passes classify, ST_MUL_A and,
// for a decay level, ST_MUL_B on the shared multiplier, the overflow check and
// bit-serial division on the shared compare/subtract unit, and the handover.
// Levels that need no division (sustain, before note on, release finished) go
// from the classify state straight to the handover. The next request can be
// accepted in the cycle after the handover. A finished result waits in the
// output register while the next request is accepted; if the receiver still
// stalls when the following result is ready, that result stays in the
// calculation unit and new requests are held off. Reset restores default
// settings and leaves the note released at time zero, with no result pending.
// ----------------------------------------------------------------------------
module adsr_envelope_generator
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] sample_time
    input  logic [1:0]                    s_tuser,   // [1:0] func
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [15:0] amplitude
    output logic [1:0]                    m_tuser,   // [1:0] stage
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [adsr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_W-1:0]    cfg_wdata
);

    adsr_pkg::cfg_t      cfg;
    adsr_pkg::note_t     note_reg;
    adsr_pkg::calc_res_t res;

    logic                          busy_reg;
    logic [adsr_pkg::TIME_W-1:0]   time_reg;
    logic                          m_valid_reg;
    logic [adsr_pkg::LEVEL_W-1:0]  m_amp_reg;
    logic [1:0]                    m_stage_reg;

    logic accept;
    logic ack;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign ack      = res.valid && (!m_valid_reg || m_tready);

    adsr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    adsr_calc u_calc
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .ack         (ack),
        .sample_time (time_reg),
        .note        (note_reg),
        .cfg         (cfg),
        .res         (res)
    );

    // Request capture and note trigger state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            note_reg.held     <= 1'b0;
            note_reg.on_time  <= '0;
            note_reg.off_time <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                time_reg <= s_tdata;
                if (s_tuser == adsr_pkg::FUNC_NOTE_ON)
                begin
                    note_reg.held    <= 1'b1;
                    note_reg.on_time <= s_tdata;
                end
                else if (s_tuser == adsr_pkg::FUNC_NOTE_OFF)
                begin
                    note_reg.held     <= 1'b0;
                    note_reg.off_time <= s_tdata;
                end
            end
            else if (ack)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Output register toward the receiver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (ack)
            begin
                m_valid_reg <= 1'b1;
                m_amp_reg   <= res.amp;
                m_stage_reg <= res.stage;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_amp_reg;
    assign m_tuser  = m_stage_reg;

endmodule
